@@ design/qmm_pkg.sv @@
// Package for the quaternion model matrix block: payload types, constants and helpers.
`default_nettype none
package qmm_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] QONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] K_012 = 32'(((64'd12 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] K_065 = 32'(((64'd65 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] K_015 = 32'(((64'd15 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] K_400 = 32'sd4 <<< FRAC_BITS;

  localparam logic [2:0] REG_SIZE_SCALE = 3'd0;
  localparam logic [2:0] REG_ANCHOR     = 3'd1;
  localparam logic [2:0] REG_CENTER_X   = 3'd2;
  localparam logic [2:0] REG_CENTER_Y   = 3'd3;
  localparam logic [2:0] REG_CENTER_Z   = 3'd4;
  localparam logic [2:0] REG_HALF_X     = 3'd5;
  localparam logic [2:0] REG_HALF_Y     = 3'd6;
  localparam logic [2:0] REG_HALF_Z     = 3'd7;

  localparam logic [1:0] ANCHOR_ORIGIN = 2'd1;
  localparam logic [1:0] ANCHOR_BOTTOM = 2'd2;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_z;
  } qmm_in_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] elem_row0;
    logic signed [31:0] elem_row1;
    logic signed [31:0] elem_row2;
    logic [16:0]        elem_row3;
    logic               last_column;
  } qmm_out_t;

  typedef struct packed {
    logic [30:0]        size_scale;
    logic [1:0]         anchor_mode;
    logic signed [31:0] ctr_x;
    logic signed [31:0] ctr_y;
    logic signed [31:0] ctr_z;
    logic signed [31:0] half_x;
    logic signed [31:0] half_y;
    logic signed [31:0] half_z;
  } qmm_cfg_t;

  // Q product with flooring shift; arithmetic shift of an exact product floors.
  function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 48'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -50'sh8000_0000) return -32'sh8000_0000;
    return 32'(x);
  endfunction

endpackage
`default_nettype wire

@@ design/quaternion_model_matrix_top.sv @@
// Top level of the quaternion to 4x4 model matrix block.
`default_nettype none
// Each accepted item (a quaternion and a position) yields four result items,
// the columns 0 to 3 of the column-major model matrix, in order. The datapath
// is a five-stage pipeline that can take an item every cycle while it does not
// stall, but the result channel carries one column per cycle while out_ready is
// high, so the sustained item rate is set by the output serializer. The uniform
// scale is computed by a bit-serial divider after reset and after every
// configuration write; no item is accepted while it runs.
// Configuration writes are always taken and must only be issued while idle.
module quaternion_model_matrix_top import qmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  qmm_in_t          in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output qmm_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  qmm_cfg_t cfg_q;
  logic signed [31:0] scale_q;
  logic scale_ok;
  logic pipe_v, pipe_en, mat_take;
  logic signed [31:0] col_q [4][3];

  assign cfg_ready = 1'b1;

  qmm_scale u_scale (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .cfg_q, .scale_q, .scale_ok
  );

  // The pipeline advances whenever its last stage is empty or being taken.
  assign pipe_en  = !pipe_v || mat_take;
  assign in_ready = pipe_en && scale_ok;

  qmm_pipe u_pipe (
    .clk, .rst_n, .en(pipe_en), .in_v(in_valid && in_ready), .in_d(in_data),
    .cfg(cfg_q), .scale(scale_q), .out_v(pipe_v), .col_q
  );

  qmm_serial u_serial (
    .clk, .rst_n, .mat_v(pipe_v), .mat_d(col_q), .mat_take,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

@@ design/qmm_scale.sv @@
// Configuration registers and the sequential divider that derives the uniform scale.
`default_nettype none
module qmm_scale import qmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output qmm_cfg_t         cfg_q,
  output logic signed [31:0] scale_q,
  output logic             scale_ok
);

  qmm_cfg_t cfg_r;
  logic [5:0]  cnt_r;
  logic        busy_r, start_r;
  logic [48:0] num_r;
  logic [32:0] den_r;
  logic [32:0] rem_r;
  logic [48:0] quo_r;
  logic signed [31:0] scale_r;

  logic signed [33:0] hmax, ext;
  logic [30:0] sz;
  logic [33:0] rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_scale  <= 31'(QONE);
      cfg_r.anchor_mode <= '0;
      cfg_r.ctr_x <= '0; cfg_r.ctr_y <= '0; cfg_r.ctr_z <= '0;
      cfg_r.half_x <= QONE; cfg_r.half_y <= QONE; cfg_r.half_z <= QONE;
      start_r <= 1'b1;
    end else begin
      start_r <= cfg_valid;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SIZE_SCALE: cfg_r.size_scale  <= cfg_data[30:0];
          REG_ANCHOR:     cfg_r.anchor_mode <= cfg_data[1:0];
          REG_CENTER_X:   cfg_r.ctr_x <= cfg_data;
          REG_CENTER_Y:   cfg_r.ctr_y <= cfg_data;
          REG_CENTER_Z:   cfg_r.ctr_z <= cfg_data;
          REG_HALF_X:     cfg_r.half_x <= cfg_data;
          REG_HALF_Y:     cfg_r.half_y <= cfg_data;
          REG_HALF_Z:     cfg_r.half_z <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    hmax = 34'(cfg_r.half_x);
    if (34'(cfg_r.half_y) > hmax) hmax = 34'(cfg_r.half_y);
    if (34'(cfg_r.half_z) > hmax) hmax = 34'(cfg_r.half_z);
    ext = hmax <<< 1;
    if (ext < 34'sd1) ext = 34'sd1;
    sz = (cfg_r.size_scale == '0) ? 31'd1 : cfg_r.size_scale;
    rem_sh = {rem_r, num_r[48]};
  end

  // Restoring divider, one quotient bit per cycle over 49 numerator bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_r) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd49;
      num_r  <= 49'(sz) << (FRAC_BITS + 1);
      den_r  <= 33'(ext);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      if (rem_sh >= 34'(den_r)) begin
        rem_r <= 33'(rem_sh - 34'(den_r));
        quo_r <= {quo_r[47:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_r[47:0], 1'b0};
      end
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r == 1'b0 && start_r == 1'b0)
      scale_r <= (quo_r > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo_r);
  end

  assign cfg_q    = cfg_r;
  assign scale_q  = scale_r;
  assign scale_ok = !busy_r && !start_r;

endmodule
`default_nettype wire

@@ design/qmm_pipe.sv @@
// Matrix datapath pipeline: products, rotation, anchor dot products and scaled columns.
`default_nettype none
module qmm_pipe import qmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_v,
  input  qmm_in_t          in_d,
  input  qmm_cfg_t         cfg,
  input  wire logic signed [31:0] scale,
  output logic             out_v,
  output logic signed [31:0] col_q [4][3]
);

  // Stage 1: quaternion products and translation products.
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [47:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic signed [47:0] t0_r, t1_r, t2_r;
  logic signed [63:0] ty_p;
  logic signed [31:0] a_nxt [3];
  logic signed [31:0] a1_r [3];
  // Stage 2: rotation entries.
  logic signed [31:0] m2_r [3][3];
  logic signed [31:0] a2_r [3];
  logic signed [49:0] t2s_r [3];
  // Stage 3: anchor products and scaled rotation.
  logic signed [47:0] ap3_r [3][3];
  logic signed [31:0] sm3_r [3][3];
  logic signed [49:0] t3_r [3];
  // Stage 4: saturated dots.
  logic signed [31:0] dot4_r [3];
  logic signed [31:0] sm4_r [3][3];
  logic signed [49:0] t4_r [3];
  // Stage 5: final columns.
  logic signed [31:0] col5_r [4][3];

  always_comb begin
    a_nxt[0] = cfg.ctr_x;
    a_nxt[1] = cfg.ctr_y;
    a_nxt[2] = cfg.ctr_z;
    if (cfg.anchor_mode == ANCHOR_ORIGIN) begin
      a_nxt[0] = '0; a_nxt[1] = '0; a_nxt[2] = '0;
    end else if (cfg.anchor_mode == ANCHOR_BOTTOM) begin
      a_nxt[1] = sat32(50'(cfg.ctr_y) - 50'(cfg.half_y));
    end
  end

  // The y offset is taken at full width, since it can leave the 32-bit range.
  always_comb begin
    ty_p = (64'(in_d.place_y) - 64'(K_065)) * 64'(K_012);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; out_v <= 1'b0;
    end else if (en) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; out_v <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= mulq(in_d.quat_x, in_d.quat_x);
      yy_r <= mulq(in_d.quat_y, in_d.quat_y);
      zz_r <= mulq(in_d.quat_z, in_d.quat_z);
      xy_r <= mulq(in_d.quat_x, in_d.quat_y);
      xz_r <= mulq(in_d.quat_x, in_d.quat_z);
      yz_r <= mulq(in_d.quat_y, in_d.quat_z);
      xw_r <= mulq(in_d.quat_x, in_d.quat_w);
      yw_r <= mulq(in_d.quat_y, in_d.quat_w);
      zw_r <= mulq(in_d.quat_z, in_d.quat_w);
      t0_r <= mulq(in_d.place_x, K_012);
      t1_r <= 48'(ty_p >>> FRAC_BITS);
      t2_r <= mulq(in_d.place_z, K_012);
      a1_r <= a_nxt;

      m2_r[0][0] <= sat32(50'(QONE) - 50'((50'(yy_r) + 50'(zz_r)) <<< 1));
      m2_r[0][1] <= sat32((50'(xy_r) - 50'(zw_r)) <<< 1);
      m2_r[0][2] <= sat32((50'(xz_r) + 50'(yw_r)) <<< 1);
      m2_r[1][0] <= sat32((50'(xy_r) + 50'(zw_r)) <<< 1);
      m2_r[1][1] <= sat32(50'(QONE) - 50'((50'(xx_r) + 50'(zz_r)) <<< 1));
      m2_r[1][2] <= sat32((50'(yz_r) - 50'(xw_r)) <<< 1);
      m2_r[2][0] <= sat32((50'(xz_r) - 50'(yw_r)) <<< 1);
      m2_r[2][1] <= sat32((50'(yz_r) + 50'(xw_r)) <<< 1);
      m2_r[2][2] <= sat32(50'(QONE) - 50'((50'(xx_r) + 50'(yy_r)) <<< 1));
      a2_r <= a1_r;
      t2s_r[0] <= 50'(t0_r);
      t2s_r[1] <= 50'(t1_r) - 50'(K_015);
      t2s_r[2] <= -50'(K_400) - 50'(t2_r);

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ap3_r[r][c] <= mulq(m2_r[r][c], a2_r[c]);
          sm3_r[r][c] <= sat32(50'(mulq(scale, m2_r[r][c])));
        end
      end
      t3_r <= t2s_r;

      for (int r = 0; r < 3; r++)
        dot4_r[r] <= sat32(50'(ap3_r[r][0]) + 50'(ap3_r[r][1]) + 50'(ap3_r[r][2]));
      sm4_r <= sm3_r;
      t4_r <= t3_r;

      for (int r = 0; r < 3; r++) begin
        col5_r[3][r] <= sat32(t4_r[r] - 50'(mulq(scale, dot4_r[r])));
        for (int c = 0; c < 3; c++)
          col5_r[c][r] <= sm4_r[r][c];
      end
    end
  end

  assign col_q = col5_r;

endmodule
`default_nettype wire

@@ design/qmm_serial.sv @@
// Output serializer: holds one finished matrix and sends it a column per item.
`default_nettype none
module qmm_serial import qmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        mat_v,
  input  wire logic signed [31:0] mat_d [4][3],
  output logic             mat_take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output qmm_out_t         out_data
);

  logic        full_r;
  logic [1:0]  col_r;
  logic signed [31:0] buf_r [4][3];
  logic        done;

  assign done     = full_r && out_ready && (col_r == 2'd3);
  assign mat_take = !full_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      col_r  <= '0;
    end else begin
      if (full_r && out_ready) col_r <= col_r + 2'd1;
      if (mat_take) full_r <= mat_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_take && mat_v) buf_r <= mat_d;
  end

  always_comb begin
    out_data.column_index = col_r;
    out_data.elem_row0    = buf_r[col_r][0];
    out_data.elem_row1    = buf_r[col_r][1];
    out_data.elem_row2    = buf_r[col_r][2];
    out_data.elem_row3    = (col_r == 2'd3) ? 17'(QONE) : 17'd0;
    out_data.last_column  = (col_r == 2'd3);
  end

  assign out_valid = full_r;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the quaternion model matrix block: directed table, random items, checking.
module tb;
  import qmm_pkg::*;

  // Clock: period 8, two delays of 4.
  logic clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  qmm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qmm_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = REG_SIZE_SCALE;
  logic [31:0] cfg_data = '0;

  quaternion_model_matrix_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The predictor keeps its own copy of every register.
  logic [30:0]        shadow_size;
  logic [1:0]         shadow_anchor;
  logic signed [31:0] shadow_center [3];
  logic signed [31:0] shadow_half [3];

  // Columns still owed by the block, oldest first.
  qmm_out_t pending_columns[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Long receiver hold-off, counted in the receiver process.
  logic hold_request = 1'b0;
  logic quiet_phase = 1'b0;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  // Exact product, arithmetic shift floors toward minus infinity.
  function automatic logic signed [63:0] qprod(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  // Works out the four columns of the model matrix for one item.
  task automatic predict_columns(input qmm_in_t item);
    logic signed [63:0] qx, qy, qz, qw, hmax, extent, scale;
    logic signed [63:0] xx, yy, zz, xy, xz, yz, xw, yw, zw, dot;
    logic signed [63:0] rot [3][3];
    logic signed [63:0] anchor [3];
    logic signed [63:0] target [3];
    logic signed [63:0] cols [4][3];
    logic [63:0] numer;
    qmm_out_t col;
    qx = item.quat_x; qy = item.quat_y; qz = item.quat_z; qw = item.quat_w;
    hmax = shadow_half[0];
    if (shadow_half[1] > hmax) hmax = shadow_half[1];
    if (shadow_half[2] > hmax) hmax = shadow_half[2];
    extent = 2 * hmax;
    if (extent < 1) extent = 1;
    numer = 64'(shadow_size == 0 ? 31'd1 : shadow_size) << (FRAC_BITS + 1);
    scale = clamp32(64'(numer / 64'(extent)));
    for (int i = 0; i < 3; i++) anchor[i] = shadow_center[i];
    if (shadow_anchor == ANCHOR_ORIGIN) begin
      for (int i = 0; i < 3; i++) anchor[i] = 0;
    end else if (shadow_anchor == ANCHOR_BOTTOM) begin
      anchor[1] = clamp32(64'(shadow_center[1]) - 64'(shadow_half[1]));
    end
    xx = qprod(qx, qx); yy = qprod(qy, qy); zz = qprod(qz, qz);
    xy = qprod(qx, qy); xz = qprod(qx, qz); yz = qprod(qy, qz);
    xw = qprod(qx, qw); yw = qprod(qy, qw); zw = qprod(qz, qw);
    rot[0][0] = clamp32(64'(QONE) - 2 * (yy + zz));
    rot[0][1] = clamp32(2 * (xy - zw));
    rot[0][2] = clamp32(2 * (xz + yw));
    rot[1][0] = clamp32(2 * (xy + zw));
    rot[1][1] = clamp32(64'(QONE) - 2 * (xx + zz));
    rot[1][2] = clamp32(2 * (yz - xw));
    rot[2][0] = clamp32(2 * (xz - yw));
    rot[2][1] = clamp32(2 * (yz + xw));
    rot[2][2] = clamp32(64'(QONE) - 2 * (xx + yy));
    target[0] = qprod(64'(item.place_x), 64'(K_012));
    target[1] = qprod(64'(item.place_y) - 64'(K_065), 64'(K_012)) - 64'(K_015);
    target[2] = -64'(K_400) - qprod(64'(item.place_z), 64'(K_012));
    for (int r = 0; r < 3; r++) begin
      dot = clamp32(qprod(rot[r][0], anchor[0]) + qprod(rot[r][1], anchor[1])
                    + qprod(rot[r][2], anchor[2]));
      cols[3][r] = clamp32(target[r] - qprod(scale, dot));
      for (int c = 0; c < 3; c++) cols[c][r] = clamp32(qprod(scale, rot[r][c]));
    end
    for (int c = 0; c < 4; c++) begin
      col.column_index = 2'(c);
      col.elem_row0 = 32'(cols[c][0]);
      col.elem_row1 = 32'(cols[c][1]);
      col.elem_row2 = 32'(cols[c][2]);
      col.elem_row3 = (c == 3) ? 17'(QONE) : 17'd0;
      col.last_column = (c == 3);
      pending_columns.push_back(col);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Checker: every accepted column is compared with the oldest one owed.
  always @(posedge clk) begin
    qmm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("unexpected column", 64'(out_data.column_index), 64'd0);
      end else begin
        want = pending_columns.pop_front();
        if (out_data.column_index != want.column_index)
          report_mismatch("column_index", 64'(out_data.column_index), 64'(want.column_index));
        if (out_data.elem_row0 != want.elem_row0)
          report_mismatch("elem_row0", 64'(out_data.elem_row0), 64'(want.elem_row0));
        if (out_data.elem_row1 != want.elem_row1)
          report_mismatch("elem_row1", 64'(out_data.elem_row1), 64'(want.elem_row1));
        if (out_data.elem_row2 != want.elem_row2)
          report_mismatch("elem_row2", 64'(out_data.elem_row2), 64'(want.elem_row2));
        if (out_data.elem_row3 != want.elem_row3)
          report_mismatch("elem_row3", 64'(out_data.elem_row3), 64'(want.elem_row3));
        if (out_data.last_column != want.last_column)
          report_mismatch("last_column", 64'(out_data.last_column), 64'(want.last_column));
      end
    end
  end

  // Receiver: ready changes at the falling edge. It stalls in random bursts,
  // holds off completely while a long stretch is requested, and is always
  // ready in the quiet phase at the end.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        // Hold off for a long stretch while the sender keeps offering items.
        repeat (60) @(negedge clk);
        out_ready <= 1'b1;
        hold_request = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_SIZE_SCALE: shadow_size = value[30:0];
      REG_ANCHOR:     shadow_anchor = value[1:0];
      REG_CENTER_X:   shadow_center[0] = value;
      REG_CENTER_Y:   shadow_center[1] = value;
      REG_CENTER_Z:   shadow_center[2] = value;
      REG_HALF_X:     shadow_half[0] = value;
      REG_HALF_Y:     shadow_half[1] = value;
      REG_HALF_Z:     shadow_half[2] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drops the input valid, waits until every owed column has come back with
  // a short settle time, and returns at a falling edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  // Offers one item at a falling edge and waits for it to be accepted; random
  // gaps before it. Valid stays high after the acceptance so that the next
  // item can follow at once; wait_drained takes it down.
  task automatic send_item(input qmm_in_t item);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_columns(item);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return -32'sh8000_0000;
      2: return $signed($urandom_range(0, 2 * 65536)) - 65536;
      default: return $signed($urandom());
    endcase
  endfunction

  // Mostly unit-range quaternions, so rotation entries stay unsaturated.
  function automatic qmm_in_t random_item();
    qmm_in_t item;
    if ($urandom_range(0, 3) != 0) begin
      item.quat_x = $signed($urandom_range(0, 131072)) - 65536;
      item.quat_y = $signed($urandom_range(0, 131072)) - 65536;
      item.quat_z = $signed($urandom_range(0, 131072)) - 65536;
      item.quat_w = $signed($urandom_range(0, 131072)) - 65536;
      item.place_x = $signed($urandom_range(0, 2097152)) - 1048576;
      item.place_y = $signed($urandom_range(0, 2097152)) - 1048576;
      item.place_z = $signed($urandom_range(0, 2097152)) - 1048576;
    end else begin
      item.quat_x = random_word(); item.quat_y = random_word();
      item.quat_z = random_word(); item.quat_w = random_word();
      item.place_x = random_word(); item.place_y = random_word();
      item.place_z = random_word();
    end
    return item;
  endfunction

  // Directed rows: quaternion extremes, identity, the zero quaternion and
  // position extremes. The identity row after reset is typed in directly.
  typedef struct {
    qmm_in_t item;
    logic    typed;
    qmm_out_t col3;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input logic signed [31:0] x, y, z, w, px, py, pz);
    directed_row_t row;
    row.item = '{x, y, z, w, px, py, pz};
    row.typed = 1'b0;
    row.col3 = '0;
    directed_rows.push_back(row);
  endtask

  initial begin
    qmm_in_t item;
    directed_row_t row;
    shadow_size = 31'(QONE);
    shadow_anchor = '0;
    for (int i = 0; i < 3; i++) begin
      shadow_center[i] = '0;
      shadow_half[i] = QONE;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity after reset: scale is 1.0 and the anchor is the bounds center
    // at zero, so the translation column is just the stage target of a zero
    // position.
    row.item = '{32'sd0, 32'sd0, 32'sd0, QONE, 32'sd0, 32'sd0, 32'sd0};
    row.typed = 1'b1;
    row.col3 = '{2'd3, 32'sd0, -(((K_065 * K_012) >>> FRAC_BITS) + 32'sd1) - K_015,
                 -K_400, 17'(QONE), 1'b1};
    directed_rows.push_back(row);
    add_row(0, 0, 0, 0, 0, 0, 0);
    add_row(32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(-32'sh8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(0, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
    add_row(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_row(QONE, QONE, QONE, QONE, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    add_row(32'sd46341, 0, 0, 32'sd46341, 32'sd65536, -32'sd65536, 32'sd1);
    add_row(-1, -1, -1, -1, -1, -1, -1);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item);
      if (directed_rows[i].typed)
        // The typed-in column replaces the predicted one.
        pending_columns[pending_columns.size() - 1] = directed_rows[i].col3;
    end
    wait_drained();

    // Special register cases: size below one lsb, degenerate bounds, bottom
    // anchor with saturation, anchor mode three, largest size.
    write_register(REG_SIZE_SCALE, 32'd0);
    write_register(REG_HALF_X, 32'd0);
    write_register(REG_HALF_Y, 32'sd5);
    write_register(REG_HALF_Z, 32'h8000_0000);
    write_register(REG_ANCHOR, 32'(ANCHOR_BOTTOM));
    write_register(REG_CENTER_Y, 32'h8000_0000);
    add_row(QONE, 0, 0, 0, 0, 0, 0);
    send_item(directed_rows[directed_rows.size() - 1].item);
    wait_drained();
    write_register(REG_SIZE_SCALE, 32'h7FFF_FFFF);
    write_register(REG_HALF_X, 32'sd65536);
    write_register(REG_ANCHOR, 32'd3);
    write_register(REG_CENTER_X, 32'h7FFF_FFFF);
    write_register(REG_CENTER_Z, 32'h8000_0000);
    send_item('{32'sd0, 32'sd0, 32'sd0, QONE, 32'sd0, 32'sd0, 32'sd0});
    send_item('{32'sd30000, -32'sd20000, 32'sd10000, 32'sd50000, 0, 0, 0});
    wait_drained();

    // Random phases, each under a fresh random configuration.
    for (int phase = 0; phase < 8; phase++) begin
      write_register(REG_SIZE_SCALE, phase == 0 ? 32'd1 : {1'b0, 31'($urandom())});
      write_register(REG_ANCHOR, 32'($urandom_range(0, 3)));
      write_register(REG_CENTER_X, random_word());
      write_register(REG_CENTER_Y, random_word());
      write_register(REG_CENTER_Z, random_word());
      write_register(REG_HALF_X, random_word());
      write_register(REG_HALF_Y, random_word());
      write_register(REG_HALF_Z, random_word());
      if (phase == 7) quiet_phase = 1'b1;
      for (int n = 0; n < 40; n++) begin
        if (phase == 2 && n == 5) hold_request = 1'b1;
        // Sender pause until every owed column has arrived.
        if (phase == 4 && n == 20) wait_drained();
        item = random_item();
        send_item(item);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_columns.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
